/* design/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    localparam int SYMBOL_COUNT   = 256;
    localparam int MAX_CODE_LEN   = 32;
    localparam int SYM_W          = 8;
    localparam int WORD_W         = 32;
    localparam int LEN_W          = 6;
    localparam int BYTE_W         = 8;
    localparam int FREE_W         = 4;
    localparam int ENTRY_W        = WORD_W + LEN_W;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(MAX_CODE_LEN < WORD_W ?
                                                     MAX_CODE_LEN : WORD_W);
    localparam logic [FREE_W-1:0] FREE_FULL = FREE_W'(BYTE_W);

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_END    = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STATUS_DATA  = 2'd0,
        STATUS_END   = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic              is_end;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } cmd_t;

endpackage

`default_nettype wire

/* design/huffman_code_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Huffman code table with MSB-first byte packer and end-of-stream report.
// ----------------------------------------------------------------------------
// Encode and end items pass the registered table read, the command queue
// and the packer's working registers; results are registered at the output.
// The packer fetches a command, then packs it in steps, where a step fills
// the current byte or finishes the code. An end item emits any partial byte
// before its end report. Reset clears the per-symbol valid flags, so every
// table entry reads as having no code; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_unit import hcbp_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output      logic              full,
    input  wire logic [1:0]        req_type,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [WORD_W-1:0] code_word,
    input  wire logic [LEN_W-1:0]  code_length,
    output      logic              empty,
    input  wire logic              pop,
    output      logic [1:0]        status,
    output      logic [BYTE_W-1:0] data_byte,
    output      logic [FREE_W-1:0] tail_bits,
    output      logic              last
);

    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;
    cmd_t cmd_out;
    logic cmd_empty;
    logic cmd_pop;

    hcbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in),
        .cmd_full    (cmd_full)
    );

    hcbp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (cmd_in),
        .q_full  (cmd_full),
        .rd_en   (cmd_pop),
        .rd_cmd  (cmd_out),
        .q_empty (cmd_empty)
    );

    hcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .status    (status),
        .data_byte (data_byte),
        .tail_bits (tail_bits),
        .last      (last)
    );

endmodule

`default_nettype wire

/* design/hcbp_ram.sv */
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/hcbp_front.sv */
// ----------------------------------------------------------------------------
// hcbp_front
// Input side: table loads, code lookup and hand-off of encode and end items.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_front import hcbp_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output      logic              full,
    input  wire logic [1:0]        req_type,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [WORD_W-1:0] code_word,
    input  wire logic [LEN_W-1:0]  code_length,
    output      logic              cmd_push,
    output      cmd_t              cmd,
    input  wire logic              cmd_full
);

    logic                    accept;
    logic                    do_load;
    logic                    do_lookup;
    logic [LEN_W-1:0]        load_len;
    logic [ENTRY_W-1:0]      entry_rd;
    logic [SYMBOL_COUNT-1:0] entry_valid_reg;
    logic [SYMBOL_COUNT-1:0] entry_valid_next;
    logic                    hit_reg;
    logic                    hold_valid_reg;
    logic                    hold_valid_next;
    logic                    hold_end_reg;

    assign full     = hold_valid_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = hold_valid_reg && !cmd_full;

    always_comb
    begin
        do_load   = 1'b0;
        do_lookup = 1'b0;
        unique case (req_t'(req_type))
            REQ_LOAD:   do_load   = accept;
            REQ_ENCODE: do_lookup = accept;
            REQ_END:    do_lookup = accept;
            default:    ;
        endcase
    end

    assign load_len = (code_length > LEN_CAP) ? LEN_CAP : code_length;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (do_load),
        .waddr (symbol),
        .wdata ({code_word, load_len}),
        .re    (do_lookup),
        .raddr (symbol),
        .rdata (entry_rd)
    );

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (do_load)
        begin
            entry_valid_next[symbol] = 1'b1;
        end
    end

    assign hold_valid_next = do_lookup || (hold_valid_reg && cmd_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            hold_valid_reg  <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            hold_valid_reg  <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_lookup)
        begin
            hit_reg      <= entry_valid_reg[symbol];
            hold_end_reg <= (req_type == REQ_END);
        end
    end

    always_comb
    begin
        cmd.is_end = hold_end_reg;
        cmd.word   = entry_rd[ENTRY_W-1:LEN_W];
        cmd.len    = hit_reg ? entry_rd[LEN_W-1:0] : '0;
    end

endmodule

`default_nettype wire

/* design/hcbp_queue.sv */
// ----------------------------------------------------------------------------
// hcbp_queue
// Short command queue between lookup and packing.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_queue import hcbp_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output      logic q_full,
    input  wire logic rd_en,
    output      cmd_t rd_cmd,
    output      logic q_empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/hcbp_back.sv */
// ----------------------------------------------------------------------------
// hcbp_back
// Bit packer: shifts code bits into the byte accumulator and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_back import hcbp_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    input  wire logic              cmd_empty,
    output      logic              cmd_pop,
    output      logic              empty,
    input  wire logic              pop,
    output      logic [1:0]        status,
    output      logic [BYTE_W-1:0] data_byte,
    output      logic [FREE_W-1:0] tail_bits,
    output      logic              last
);

    logic              busy_reg,    busy_next;
    logic              is_end_reg,  is_end_next;
    logic [WORD_W-1:0] word_reg,    word_next;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic [BYTE_W-1:0] acc_reg,     acc_next;
    logic [FREE_W-1:0] free_reg,    free_next;
    logic              aborted_reg, aborted_next;
    logic [FREE_W-1:0] vb_reg,      vb_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [FREE_W-1:0] out_vb_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              emit;
    status_t           emit_status;
    logic [BYTE_W-1:0] emit_byte;
    logic [FREE_W-1:0] emit_vb;
    logic              emit_last;

    logic [FREE_W-1:0] take;
    logic [LEN_W-1:0]  shift;
    logic [BYTE_W-1:0] chunk;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] packed_acc;
    logic [FREE_W-1:0] packed_free;
    logic [LEN_W-1:0]  packed_len;

    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        take        = (len_reg < LEN_W'(free_reg)) ? FREE_W'(len_reg) : free_reg;
        shift       = len_reg - LEN_W'(take);
        mask        = BYTE_W'((9'd1 << take) - 9'd1);
        chunk       = BYTE_W'(word_reg >> shift) & mask;
        packed_acc  = acc_reg | BYTE_W'(chunk << (free_reg - take));
        packed_free = free_reg - take;
        packed_len  = len_reg - LEN_W'(take);
    end

    always_comb
    begin
        busy_next    = busy_reg;
        is_end_next  = is_end_reg;
        word_next    = word_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        free_next    = free_reg;
        aborted_next = aborted_reg;
        vb_next      = vb_reg;
        cmd_pop      = 1'b0;
        emit         = 1'b0;
        emit_status  = STATUS_DATA;
        emit_byte    = '0;
        emit_vb      = '0;
        emit_last    = 1'b0;

        if (!busy_reg)
        begin
            if (!cmd_empty)
            begin
                cmd_pop = 1'b1;
                if (cmd.is_end || !aborted_reg)
                begin
                    busy_next   = 1'b1;
                    is_end_next = cmd.is_end;
                    word_next   = cmd.word;
                    len_next    = cmd.len;
                    vb_next     = FREE_FULL;
                end
            end
        end
        else if (is_end_reg)
        begin
            if (out_free)
            begin
                emit = 1'b1;
                if (aborted_reg || free_reg == FREE_FULL)
                begin
                    emit_status  = STATUS_END;
                    emit_vb      = aborted_reg ? '0 : vb_reg;
                    emit_last    = 1'b1;
                    acc_next     = '0;
                    free_next    = FREE_FULL;
                    aborted_next = 1'b0;
                    busy_next    = 1'b0;
                end
                else
                begin
                    emit_byte = acc_reg;
                    vb_next   = FREE_FULL - free_reg;
                    acc_next  = '0;
                    free_next = FREE_FULL;
                end
            end
        end
        else if (len_reg == '0)
        begin
            if (out_free)
            begin
                emit         = 1'b1;
                emit_status  = STATUS_ERROR;
                emit_last    = 1'b1;
                acc_next     = '0;
                free_next    = FREE_FULL;
                aborted_next = 1'b1;
                busy_next    = 1'b0;
            end
        end
        else if (packed_free == '0)
        begin
            if (out_free)
            begin
                emit      = 1'b1;
                emit_byte = packed_acc;
                emit_last = (packed_len < LEN_W'(BYTE_W));
                acc_next  = '0;
                free_next = FREE_FULL;
                len_next  = packed_len;
                busy_next = (packed_len != '0);
            end
        end
        else
        begin
            acc_next  = packed_acc;
            free_next = packed_free;
            len_next  = '0;
            busy_next = 1'b0;
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            acc_reg       <= '0;
            free_reg      <= FREE_FULL;
            aborted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            acc_reg       <= acc_next;
            free_reg      <= free_next;
            aborted_reg   <= aborted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_end_reg <= is_end_next;
        word_reg   <= word_next;
        len_reg    <= len_next;
        vb_reg     <= vb_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_byte_reg   <= emit_byte;
            out_vb_reg     <= emit_vb;
            out_last_reg   <= emit_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign status    = out_status_reg;
    assign data_byte = out_byte_reg;
    assign tail_bits = out_vb_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks huffman_code_bit_packer_unit: code table loads, MSB-first byte
// packing, end-of-stream reports and missing-code aborts, against an
// in-bench model of the packer, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct {
        status_t            status;
        logic [BYTE_W-1:0]  data;
        logic [FREE_W-1:0]  tail_bits;
        logic               last;
    } packed_result_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [1:0]        req_type;
    logic [SYM_W-1:0]  symbol;
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic              empty;
    logic              pop;
    logic [1:0]        status;
    logic [BYTE_W-1:0] data_byte;
    logic [FREE_W-1:0] tail_bits;
    logic              last;

    logic [WORD_W-1:0] table_words   [SYMBOL_COUNT];
    logic [LEN_W-1:0]  table_lengths [SYMBOL_COUNT];
    logic [BYTE_W-1:0] byte_acc;
    logic [FREE_W-1:0] free_bits;
    logic              stream_aborted;

    packed_result_t    byte_stream_due[$];

    int send_idle_pct   = 0;
    int pop_stall_pct   = 0;
    int pop_hold_cycles = 0;
    int failures        = 0;

    huffman_code_bit_packer_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .data_byte   (data_byte),
        .tail_bits   (tail_bits),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #2ms;
        $display("testbench failed");
        $finish;
    end

    function automatic packed_result_t make_result(input status_t st,
                                                   input logic [BYTE_W-1:0] data,
                                                   input logic [FREE_W-1:0] vb);
        packed_result_t r;
        r.status    = st;
        r.data      = data;
        r.tail_bits = vb;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic void pack_request(input logic [1:0]        req,
                                         input logic [SYM_W-1:0]  sym,
                                         input logic [WORD_W-1:0] word,
                                         input logic [LEN_W-1:0]  len);
        packed_result_t due[$];
        int             bit_idx;
        case (req)
            REQ_LOAD:
            begin
                table_words[sym]   = word;
                table_lengths[sym] = (len > LEN_CAP) ? LEN_CAP : len;
            end
            REQ_ENCODE:
            begin
                if (!stream_aborted)
                begin
                    if (table_lengths[sym] == '0)
                    begin
                        due.push_back(make_result(STATUS_ERROR, '0, '0));
                        stream_aborted = 1'b1;
                        byte_acc       = '0;
                        free_bits      = FREE_FULL;
                    end
                    else
                    begin
                        for (bit_idx = int'(table_lengths[sym]) - 1; bit_idx >= 0;
                             bit_idx--)
                        begin
                            free_bits           = free_bits - 1'b1;
                            byte_acc[free_bits] = table_words[sym][bit_idx];
                            if (free_bits == '0)
                            begin
                                due.push_back(make_result(STATUS_DATA, byte_acc, '0));
                                byte_acc  = '0;
                                free_bits = FREE_FULL;
                            end
                        end
                    end
                end
            end
            REQ_END:
            begin
                if (stream_aborted)
                    due.push_back(make_result(STATUS_END, '0, '0));
                else if (free_bits != FREE_FULL)
                begin
                    due.push_back(make_result(STATUS_DATA, byte_acc, '0));
                    due.push_back(make_result(STATUS_END, '0, FREE_FULL - free_bits));
                end
                else
                    due.push_back(make_result(STATUS_END, '0, FREE_FULL));
                byte_acc       = '0;
                free_bits      = FREE_FULL;
                stream_aborted = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (due.size() > 0)
            due[$].last = 1'b1;
        foreach (due[i])
            byte_stream_due.push_back(due[i]);
    endfunction

    function automatic logic [LEN_W-1:0] pick_code_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return LEN_W'($urandom_range(1, 8));
        if (roll < 90)
            return LEN_W'($urandom_range(9, 32));
        return LEN_W'($urandom_range(33, 63));
    endfunction

    task automatic send_item(input logic [1:0]        req,
                             input logic [SYM_W-1:0]  sym,
                             input logic [WORD_W-1:0] word,
                             input logic [LEN_W-1:0]  len);
        push        <= 1'b1;
        req_type    <= req;
        symbol      <= sym;
        code_word   <= word;
        code_length <= len;
        do
            @(posedge clk);
        while (full);
        pack_request(req, sym, word, len);
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_until_drained();
        push <= 1'b0;
        while (byte_stream_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_stream_control();
        send_item(REQ_END, 8'h00, '0, '0);
        send_item(REQ_ENCODE, 8'h00, '0, '0);
        send_item(REQ_ENCODE, 8'h01, '0, '0);
        send_item(REQ_END, 8'h00, '0, '0);
        send_item(REQ_UNKNOWN, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        send_item(REQ_LOAD, 8'h10, 32'h5, 6'd3);
        send_item(REQ_ENCODE, 8'h10, '0, '0);
        send_item(REQ_ENCODE, 8'h10, '0, '0);
        send_item(REQ_END, 8'h00, '0, '0);
        wait_until_drained();
    endtask

    task automatic test_code_table();
        send_item(REQ_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_item(REQ_LOAD, 8'h00, 32'h1, 6'd1);
        send_item(REQ_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd63);
        send_item(REQ_LOAD, 8'h7F, 32'h0, 6'd33);
        send_item(REQ_LOAD, 8'h55, 32'hFFFF_FFF5, 6'd4);
        send_item(REQ_ENCODE, 8'hFF, '0, '0);
        repeat (3) send_item(REQ_ENCODE, 8'h00, '0, '0);
        send_item(REQ_ENCODE, 8'h55, '0, '0);
        send_item(REQ_LOAD, 8'h00, 32'h2, 6'd2);
        send_item(REQ_ENCODE, 8'h00, '0, '0);
        send_item(REQ_END, 8'h00, '0, '0);
        send_item(REQ_ENCODE, 8'h80, '0, '0);
        send_item(REQ_ENCODE, 8'h7F, '0, '0);
        send_item(REQ_END, 8'h00, '0, '0);
        send_item(REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
        send_item(REQ_ENCODE, 8'h00, '0, '0);
        send_item(REQ_END, 8'h00, '0, '0);
        wait_until_drained();
    endtask

    task automatic test_random_streams(input int item_goal, input int sender_pct,
                                       input int stall_pct);
        int               sent;
        int               roll;
        logic [SYM_W-1:0] sym;
        send_idle_pct = sender_pct;
        pop_stall_pct = stall_pct;
        sent          = 0;
        for (int s = 0; s < 8; s++)
            send_item(REQ_LOAD, SYM_W'(s), $urandom, pick_code_length());
        while (sent < item_goal)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                send_item(REQ_LOAD, SYM_W'($urandom_range(0, 7)), $urandom,
                          ($urandom_range(99) < 80) ? pick_code_length() : '0);
                sent++;
            end
            else if (roll < 14)
                send_item(REQ_UNKNOWN, SYM_W'($urandom), $urandom, LEN_W'($urandom));
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    sym = ($urandom_range(99) < 5) ? SYM_W'($urandom)
                                                   : SYM_W'($urandom_range(0, 7));
                    send_item(REQ_ENCODE, sym, $urandom, LEN_W'($urandom));
                    sent++;
                end
                if ($urandom_range(99) < 85)
                begin
                    send_item(REQ_END, SYM_W'($urandom), $urandom, LEN_W'($urandom));
                    sent++;
                end
            end
        end
        send_item(REQ_END, 8'h00, '0, '0);
        wait_until_drained();
    endtask

    task automatic test_back_pressure();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_item(REQ_LOAD, 8'hF0, $urandom, 6'd32);
        send_item(REQ_LOAD, 8'hF1, $urandom, 6'd20);
        pop_hold_cycles = 300;
        repeat (16)
            send_item(REQ_ENCODE, $urandom_range(1) ? 8'hF0 : 8'hF1, '0, '0);
        send_item(REQ_END, 8'h00, '0, '0);
        wait_until_drained();
    endtask

    initial
    begin
        packed_result_t due;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (byte_stream_due.size() == 0)
                begin
                    $error("unexpected result: status %0d data_byte %02h tail_bits %0d",
                           status, data_byte, tail_bits);
                    failures++;
                end
                else
                begin
                    due = byte_stream_due.pop_front();
                    if (status !== due.status)
                    begin
                        $error("status: expected %0d, actual %0d", due.status, status);
                        failures++;
                    end
                    if (data_byte !== due.data)
                    begin
                        $error("data_byte: expected %02h, actual %02h", due.data, data_byte);
                        failures++;
                    end
                    if (tail_bits !== due.tail_bits)
                    begin
                        $error("tail_bits: expected %0d, actual %0d", due.tail_bits,
                               tail_bits);
                        failures++;
                    end
                    if (last !== due.last)
                    begin
                        $error("last: expected %0b, actual %0b", due.last, last);
                        failures++;
                    end
                end
            end
            if (pop_hold_cycles > 0)
            begin
                pop_hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        req_type    = REQ_LOAD;
        symbol      = '0;
        code_word   = '0;
        code_length = '0;
        foreach (table_words[i])
        begin
            table_words[i]   = '0;
            table_lengths[i] = '0;
        end
        byte_acc       = '0;
        free_bits      = FREE_FULL;
        stream_aborted = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stream_control();
        test_code_table();
        test_random_streams(8, 0, 0);
        test_random_streams(8, 50, 0);
        test_random_streams(8, 0, 50);
        test_random_streams(8, 35, 35);
        test_back_pressure();

        pop_stall_pct = 0;
        wait_until_drained();
        repeat (16) @(posedge clk);
        if (byte_stream_due.size() != 0)
        begin
            $error("%0d expected results never arrived", byte_stream_due.size());
            failures++;
        end
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
design/hcbp_pkg.sv
design/hcbp_ram.sv
design/hcbp_front.sv
design/hcbp_queue.sv
design/hcbp_back.sv
design/huffman_code_bit_packer_unit.sv
tb/testbench.sv
